/* hw/rtl/srdz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srdz_pkg;

   localparam int FULL_SCALE    = 32767;
   localparam int LEFT_DZ_RST   = 7849;
   localparam int RIGHT_DZ_RST  = 8689;
   localparam int HALF_PI_Q12   = 6434;
   localparam int PI_Q12        = 12868;
   localparam logic [31:0] PI_TIMES_2P30 = 32'd3373259426;
   localparam int TABLE_LEN     = 24;
   localparam int CORDIC_STEPS_DEF = 16;

   // root of r2 * 2^16 needs 23 result bits, quotient needs 16
   localparam int SQRT_CELLS = 23;
   localparam int DIV_CELLS  = 16;
   localparam int SQ_W       = 47;
   localparam int CX_W       = 27;
   localparam int CZ_W       = 33;

   localparam logic [31:0] FULL_SCALE_SQ = 32'd1073676289;
   localparam logic [22:0] FULL_SCALE_L8 = 23'd8388352;

   typedef struct packed {
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic               stick_sel;
   } req_type;

   typedef struct packed {
      logic [15:0]        magnitude;
      logic signed [15:0] angle;
      logic               stick_id;
   } rsp_type;

   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [23:0] rem;
      logic [15:0] q;
      logic [22:0] d;
   } div_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [CZ_W-1:0] z;
   } cordic_type;

   // atan(2^-i) with a full turn of 2^32
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] t;
      unique case (idx)
         0:  t = 32'h20000000;
         1:  t = 32'h12E4051E;
         2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;
         4:  t = 32'h028B0D43;
         5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;
         7:  t = 32'h00517C55;
         8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;
         10: t = 32'h000A2F98;
         11: t = 32'h000517CC;
         12: t = 32'h00028BE6;
         13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;
         16: t = 32'h000028BE;
         17: t = 32'h0000145F;
         18: t = 32'h00000A30;
         19: t = 32'h00000518;
         20: t = 32'h0000028C;
         21: t = 32'h00000146;
         22: t = 32'h000000A3;
         23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/stick_radial_deadzone_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Radial dead zone and polar form of one thumbstick sample. Each transfer on
// the req_ channel carries (stick_x, stick_y, stick_sel); each rsp_ transfer
// returns magnitude (unsigned Q0.16, zero inside the selected dead zone,
// saturating at 65535), angle (signed Q3.12 radians, -pi/2..3pi/2) and the
// echoed stick_id. One sample enters per cycle while the pipeline advances;
// it passes stage A, stage B, the bit-per-cell square root chain, stage C,
// the bit-per-cell divider chain and the output register. The angle comes
// from a CORDIC chain of CORDIC_STEPS cells (at most 24) running alongside.
// The whole pipeline advances whenever the output register is empty or taken.
// Dead zones sit in two APB registers: left at 0x0, right at 0x4.

module stick_radial_deadzone_unit
   import srdz_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int STEPS   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int LAT     = SQRT_CELLS + DIV_CELLS + 4;
   localparam int ANG_DLY = SQRT_CELLS + DIV_CELLS - 1 - STEPS;
   localparam int SQS_W   = 18;
   localparam int DVS_W   = 3;
   localparam int CDS_W   = 18;

   // ---------------- configuration registers
   logic [14:0] left_dz_ff, right_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff  <= 15'(LEFT_DZ_RST);
         right_dz_ff <= 15'(RIGHT_DZ_RST);
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) right_dz_ff <= pwdata[14:0];
         else          left_dz_ff  <= pwdata[14:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = {17'b0, (paddr[2] ? right_dz_ff : left_dz_ff)};

   // ---------------- pipeline advance
   logic           en;
   logic [LAT-1:0] vld_ff;

   // refuse transfers while reset is held
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en && !reset;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------- stage A: capture and square
   logic signed [15:0] a_x_ff, a_y_ff;
   logic               a_sel_ff;
   logic [14:0]        a_dz_ff;
   logic [31:0]        a_xx_ff, a_yy_ff;
   logic [29:0]        a_dzsq_ff;
   logic signed [31:0] sx, sy;
   logic [14:0]        dz_sel;

   always_comb begin
      sx     = 32'(req_data.stick_x);
      sy     = 32'(req_data.stick_y);
      dz_sel = req_data.stick_sel ? right_dz_ff : left_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= req_data.stick_x;
         a_y_ff    <= req_data.stick_y;
         a_sel_ff  <= req_data.stick_sel;
         a_dz_ff   <= dz_sel;
         a_xx_ff   <= 32'(sx * sx);
         a_yy_ff   <= 32'(sy * sy);
         a_dzsq_ff <= 30'(dz_sel * dz_sel);
      end
   end

   // ---------------- stage B: squared length, dead zone and clamp flags
   sqrt_type           sq_d [SQRT_CELLS+1];
   logic [SQS_W-1:0]   sq_s [SQRT_CELLS+1];
   sqrt_type           b_sq_ff;
   logic [SQS_W-1:0]   b_side_ff;
   logic [31:0]        r2;
   logic               b_zero, b_sat;

   always_comb begin
      r2     = a_xx_ff + a_yy_ff;
      b_zero = (a_dz_ff == 15'h7FFF) || (r2 <= {2'b0, a_dzsq_ff});
      b_sat  = r2 > FULL_SCALE_SQ;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_sq_ff.v    <= b_sat ? '0 : SQ_W'({r2[29:0], 16'b0});
         b_sq_ff.root <= '0;
         b_side_ff    <= {a_sel_ff, b_zero, b_sat, a_dz_ff};
      end
   end

   assign sq_d[0] = b_sq_ff;
   assign sq_s[0] = b_side_ff;

   // ---------------- square root chain, one root bit per cell
   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      srdz_sqrt_cell #(
         .K      (SQRT_CELLS - 1 - k),
         .SIDE_W (SQS_W)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .d_in     (sq_d[k]),
         .side_in  (sq_s[k]),
         .d_out    (sq_d[k+1]),
         .side_out (sq_s[k+1])
      );
   end

   // ---------------- stage C: divider setup
   div_type          dv_d [DIV_CELLS+1];
   logic [DVS_W-1:0] dv_s [DIV_CELLS+1];
   div_type          c_dv_ff;
   logic [DVS_W-1:0] c_side_ff;
   logic [14:0]      c_dz;
   logic [22:0]      l8, den;
   logic [23:0]      num;

   always_comb begin
      c_dz = sq_s[SQRT_CELLS][14:0];
      l8   = sq_s[SQRT_CELLS][15] ? FULL_SCALE_L8 : sq_d[SQRT_CELLS].root[22:0];
      num  = {1'b0, l8} - {1'b0, c_dz, 8'b0};
      den  = {15'(FULL_SCALE) - c_dz, 8'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_dv_ff.rem <= num;
         c_dv_ff.q   <= '0;
         c_dv_ff.d   <= den;
         // quotient reaches 65536 only at full length: saturate
         c_side_ff   <= {sq_s[SQRT_CELLS][17], sq_s[SQRT_CELLS][16],
                         (num >= {1'b0, den})};
      end
   end

   assign dv_d[0] = c_dv_ff;
   assign dv_s[0] = c_side_ff;

   // ---------------- divider chain, one quotient bit per cell
   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      srdz_div_cell #(
         .SIDE_W (DVS_W)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .d_in     (dv_d[k]),
         .side_in  (dv_s[k]),
         .d_out    (dv_d[k+1]),
         .side_out (dv_s[k+1])
      );
   end

   // ---------------- angle: fold into the right half plane
   cordic_type          cd_d [STEPS+1];
   logic [CDS_W-1:0]    cd_s [STEPS+1];
   cordic_type          p_cd_ff;
   logic [CDS_W-1:0]    p_side_ff;
   logic signed [CX_W-1:0] px, py;
   logic signed [15:0]  spec_val;

   always_comb begin
      px = CX_W'(a_x_ff);
      py = CX_W'(a_y_ff);
      if (a_x_ff[15]) begin
         px = -px;
         py = -py;
      end
      if (a_y_ff[15])           spec_val = -16'sd6434;
      else if (a_y_ff != 16'sd0) spec_val = 16'(HALF_PI_Q12);
      else                      spec_val = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_cd_ff.x <= px <<< 8;
         p_cd_ff.y <= py <<< 8;
         p_cd_ff.z <= '0;
         p_side_ff <= {a_x_ff[15], (a_x_ff == 16'sd0), spec_val};
      end
   end

   assign cd_d[0] = p_cd_ff;
   assign cd_s[0] = p_side_ff;

   // ---------------- CORDIC chain, one vectoring step per cell
   for (genvar k = 0; k < STEPS; k++) begin : g_cordic
      srdz_cordic_cell #(
         .I      (k),
         .SIDE_W (CDS_W)
      ) u_cell (
         .clock    (clock),
         .en       (en),
         .d_in     (cd_d[k]),
         .side_in  (cd_s[k]),
         .d_out    (cd_d[k+1]),
         .side_out (cd_s[k+1])
      );
   end

   // ---------------- angle: scale turn fraction to radians
   logic [63:0]      m_prod_ff;
   logic             m_neg_ff;
   logic [CDS_W-1:0] m_side_ff;
   logic [CZ_W-1:0]  zabs;

   always_comb begin
      zabs = cd_d[STEPS].z[CZ_W-1] ? CZ_W'(-cd_d[STEPS].z) : CZ_W'(cd_d[STEPS].z);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= zabs[31:0] * PI_TIMES_2P30;
         m_neg_ff  <= cd_d[STEPS].z[CZ_W-1];
         m_side_ff <= cd_s[STEPS];
      end
   end

   // round half away, clamp to pi/2, apply sign and base
   logic [64:0]        rnd;
   logic [15:0]        q;
   logic signed [15:0] ang;

   always_comb begin
      rnd = {1'b0, m_prod_ff} + (65'(1) << 48);
      q   = rnd[64:49];
      if (q > 16'(HALF_PI_Q12)) q = 16'(HALF_PI_Q12);
      ang = (m_side_ff[17] ? 16'(PI_Q12) : 16'sd0) + (m_neg_ff ? -$signed(q) : $signed(q));
      if (m_side_ff[16]) ang = m_side_ff[15:0];
   end

   // hold the angle until the magnitude catches up
   logic signed [15:0] ang_dly_ff [ANG_DLY+1];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_dly_ff[0] <= ang;
         for (int i = 1; i <= ANG_DLY; i++) begin
            ang_dly_ff[i] <= ang_dly_ff[i-1];
         end
      end
   end

   // ---------------- output register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.magnitude <= dv_s[DIV_CELLS][1] ? 16'h0 :
                             dv_s[DIV_CELLS][0] ? 16'hFFFF : dv_d[DIV_CELLS].q;
         rsp_ff.angle     <= ang_dly_ff[ANG_DLY];
         rsp_ff.stick_id  <= dv_s[DIV_CELLS][2];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/srdz_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module srdz_sqrt_cell
   import srdz_pkg::*;
#(
   parameter int K      = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire sqrt_type          d_in,
   input  wire logic [SIDE_W-1:0] side_in,
   output sqrt_type               d_out,
   output logic [SIDE_W-1:0]      side_out
);

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

   sqrt_type        d_ff, d_in_nx;
   logic [SQ_W-1:0] sum;

   // one result bit: try root + bit against the remainder
   always_comb begin
      sum = d_in.root + BIT;
      if (d_in.v >= sum) begin
         d_in_nx.v    = d_in.v - sum;
         d_in_nx.root = (d_in.root >> 1) + BIT;
      end else begin
         d_in_nx.v    = d_in.v;
         d_in_nx.root = d_in.root >> 1;
      end
   end

   logic [SIDE_W-1:0] side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in_nx;
         side_ff <= side_in;
      end
   end

   assign d_out    = d_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

/* hw/rtl/srdz_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module srdz_div_cell
   import srdz_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire div_type           d_in,
   input  wire logic [SIDE_W-1:0] side_in,
   output div_type                d_out,
   output logic [SIDE_W-1:0]      side_out
);

   div_type           d_ff, d_in_nx;
   logic [23:0]       t;
   logic [SIDE_W-1:0] side_ff;

   // one restoring quotient bit
   always_comb begin
      t         = {d_in.rem[22:0], 1'b0};
      d_in_nx.d = d_in.d;
      if (t >= {1'b0, d_in.d}) begin
         d_in_nx.rem = t - {1'b0, d_in.d};
         d_in_nx.q   = {d_in.q[14:0], 1'b1};
      end else begin
         d_in_nx.rem = t;
         d_in_nx.q   = {d_in.q[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in_nx;
         side_ff <= side_in;
      end
   end

   assign d_out    = d_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

/* hw/rtl/srdz_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module srdz_cordic_cell
   import srdz_pkg::*;
#(
   parameter int I      = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire cordic_type        d_in,
   input  wire logic [SIDE_W-1:0] side_in,
   output cordic_type             d_out,
   output logic [SIDE_W-1:0]      side_out
);

   localparam logic signed [CZ_W-1:0] ATAN = $signed({1'b0, atan_turn(I)});

   cordic_type        d_ff, d_in_nx;
   logic [SIDE_W-1:0] side_ff;

   // rotate toward the x axis, floor shifts
   always_comb begin
      if (!d_in.y[CX_W-1]) begin
         d_in_nx.x = d_in.x + (d_in.y >>> I);
         d_in_nx.y = d_in.y - (d_in.x >>> I);
         d_in_nx.z = d_in.z + ATAN;
      end else begin
         d_in_nx.x = d_in.x - (d_in.y >>> I);
         d_in_nx.y = d_in.y + (d_in.x >>> I);
         d_in_nx.z = d_in.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in_nx;
         side_ff <= side_in;
      end
   end

   assign d_out    = d_ff;
   assign side_out = side_ff;

endmodule

`default_nettype wire

/* hw/rtl/srdz_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module srdz_checker
   import srdz_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data,
   input wire logic    pready
);

   // drop the pipeline on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // accept input whenever the output stage is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("ready low with free output");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.angle >= -16'sd6434) && (rsp_data.angle <= 16'sd19302))
      else $error("angle out of range");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind stick_radial_deadzone_unit srdz_checker u_srdz_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

`default_nettype wire
